FILE: rtl/sce_pkg.sv
package sce_pkg;

	// Fixed-point constants
	localparam int ONE_Q        = 16384;
	localparam int HALF_TURN    = 32768;
	localparam int QW           = 18;    // quotient bits of the shared divider
	localparam int CORDIC_STEPS = 15;
	localparam int CW           = 26;    // CORDIC vector width
	localparam int ZW           = 18;    // angle accumulator width
	localparam int AW           = 18;    // table entry and result width
	localparam int ANGLE_MIN    = -32768;
	localparam int ANGLE_MAX    = 98304;

	typedef enum logic [0:0] {
		OP_LOAD   = 1'b0,
		OP_SAMPLE = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		REG_ENABLE = 3'd0,
		REG_MIN_X  = 3'd1,
		REG_MAX_X  = 3'd2,
		REG_MIN_Y  = 3'd3,
		REG_MAX_Y  = 3'd4
	} reg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_DECIDE,
		ST_NX, ST_DXG, ST_DXW,
		ST_NY, ST_DYG, ST_DYW,
		ST_CINIT, ST_CRUN,
		ST_RD0, ST_JMP, ST_URD, ST_UCHK, ST_DRD, ST_DCHK, ST_ORD, ST_OCHK,
		ST_MUL, ST_DSET, ST_DG, ST_DW, ST_FIN, ST_EMIT
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic latch;
		logic load_we;
		logic res_zero;
		logic res_last;
		logic norm_x;
		logic norm_y;
		logic store_x;
		logic store_y;
		logic div_start;
		logic cor_init;
		logic cor_step;
		logic rd_p;
		logic rd_pm1;
		logic jump;
		logic up_step;
		logic dn_step;
		logic store_under;
		logic store_over;
		logic mul;
		logic dset;
		logic finish;
		logic emit;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic op_load;
		logic enabled;
		logic disc;
		logic div_busy;
		logic cor_last;
		logic up_go;
		logic dn_go;
		logic out_free;
	} st_t;

	// Arctangent of 2^-i in units where 65536 is one turn
	function automatic logic [13:0] atan_unit(input logic [3:0] i);
		logic [13:0] v;
		unique case (i)
			4'd0:    v = 14'd8192;
			4'd1:    v = 14'd4836;
			4'd2:    v = 14'd2555;
			4'd3:    v = 14'd1297;
			4'd4:    v = 14'd651;
			4'd5:    v = 14'd326;
			4'd6:    v = 14'd163;
			4'd7:    v = 14'd81;
			4'd8:    v = 14'd41;
			4'd9:    v = 14'd20;
			4'd10:   v = 14'd10;
			4'd11:   v = 14'd5;
			4'd12:   v = 14'd3;
			4'd13:   v = 14'd1;
			4'd14:   v = 14'd1;
			default: v = 14'd0;
		endcase
		return v;
	endfunction

endpackage

FILE: rtl/sce_div.sv
module sce_div #(
	parameter int NUMW = 47,
	parameter int DENW = 29
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [NUMW-1:0]        num,
	input  logic [DENW-1:0]        den,
	output logic                   busy,
	output logic [sce_pkg::QW-1:0] quo,
	output logic                   ovf
);

	localparam int QW   = sce_pkg::QW;
	localparam int HW   = NUMW - QW;
	localparam int XW   = ((HW > DENW) ? HW : DENW) + 1;
	localparam int CNTW = $clog2(QW);

	logic            busy_q;
	logic [CNTW-1:0] cnt_q;
	logic [DENW-1:0] rem_q;
	logic [DENW-1:0] den_q;
	logic [QW-1:0]   low_q;
	logic            ovf_q;

	logic [HW-1:0]   hi;
	logic [XW-1:0]   hi_x;
	logic [XW-1:0]   den_x;
	logic [DENW:0]   rem2;
	logic            fits;

	// Quotient must fit QW bits, otherwise flag overflow
	assign hi    = num[NUMW-1:QW];
	assign hi_x  = XW'(hi);
	assign den_x = XW'(den);
	assign rem2  = {rem_q, low_q[QW-1]};
	assign fits  = rem2 >= {1'b0, den_q};

	// Iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNTW'(QW - 1))
				busy_q <= 1'b0;
		end
	end

	// Restoring division, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DENW'(hi);
			low_q <= num[QW-1:0];
			den_q <= den;
			ovf_q <= hi_x >= den_x;
		end else if (busy_q) begin
			if (fits)
				rem_q <= DENW'(rem2 - {1'b0, den_q});
			else
				rem_q <= rem2[DENW-1:0];
			low_q <= {low_q[QW-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign quo  = low_q;
	assign ovf  = ovf_q;

endmodule

FILE: rtl/sce_ctrl.sv
module sce_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_valid,
	output logic             s_ready,
	output sce_pkg::cmd_t    cmd,
	input  sce_pkg::st_t     st
);

	sce_pkg::state_t state_q;
	sce_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= sce_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	assign s_ready = (state_q == sce_pkg::ST_IDLE);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sce_pkg::ST_IDLE:   if (s_valid) state_d = sce_pkg::ST_DECIDE;
			sce_pkg::ST_DECIDE: begin
				priority if (st.op_load)  state_d = sce_pkg::ST_IDLE;
				else if (!st.enabled)     state_d = sce_pkg::ST_EMIT;
				else if (st.disc)         state_d = sce_pkg::ST_EMIT;
				else                      state_d = sce_pkg::ST_NX;
			end
			sce_pkg::ST_NX:     state_d = sce_pkg::ST_DXG;
			sce_pkg::ST_DXG:    state_d = sce_pkg::ST_DXW;
			sce_pkg::ST_DXW:    if (!st.div_busy) state_d = sce_pkg::ST_NY;
			sce_pkg::ST_NY:     state_d = sce_pkg::ST_DYG;
			sce_pkg::ST_DYG:    state_d = sce_pkg::ST_DYW;
			sce_pkg::ST_DYW:    if (!st.div_busy) state_d = sce_pkg::ST_CINIT;
			sce_pkg::ST_CINIT:  state_d = sce_pkg::ST_CRUN;
			sce_pkg::ST_CRUN:   if (st.cor_last) state_d = sce_pkg::ST_RD0;
			sce_pkg::ST_RD0:    state_d = sce_pkg::ST_JMP;
			sce_pkg::ST_JMP:    state_d = sce_pkg::ST_URD;
			sce_pkg::ST_URD:    state_d = sce_pkg::ST_UCHK;
			sce_pkg::ST_UCHK:   state_d = st.up_go ? sce_pkg::ST_URD : sce_pkg::ST_DRD;
			sce_pkg::ST_DRD:    state_d = sce_pkg::ST_DCHK;
			sce_pkg::ST_DCHK:   state_d = st.dn_go ? sce_pkg::ST_DRD : sce_pkg::ST_ORD;
			sce_pkg::ST_ORD:    state_d = sce_pkg::ST_OCHK;
			sce_pkg::ST_OCHK:   state_d = sce_pkg::ST_MUL;
			sce_pkg::ST_MUL:    state_d = sce_pkg::ST_DSET;
			sce_pkg::ST_DSET:   state_d = sce_pkg::ST_DG;
			sce_pkg::ST_DG:     state_d = sce_pkg::ST_DW;
			sce_pkg::ST_DW:     if (!st.div_busy) state_d = sce_pkg::ST_FIN;
			sce_pkg::ST_FIN:    state_d = sce_pkg::ST_EMIT;
			sce_pkg::ST_EMIT:   if (st.out_free) state_d = sce_pkg::ST_IDLE;
			default:            state_d = sce_pkg::ST_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd       = '0;
		cmd.latch = s_valid && (state_q == sce_pkg::ST_IDLE);
		unique case (state_q)
			sce_pkg::ST_DECIDE: begin
				cmd.load_we  = st.op_load;
				cmd.res_zero = !st.op_load && !st.enabled;
				cmd.res_last = !st.op_load && st.enabled && st.disc;
			end
			sce_pkg::ST_NX:    cmd.norm_x = 1'b1;
			sce_pkg::ST_NY:    cmd.norm_y = 1'b1;
			sce_pkg::ST_DXG,
			sce_pkg::ST_DYG,
			sce_pkg::ST_DG:    cmd.div_start = 1'b1;
			sce_pkg::ST_DXW:   cmd.store_x = !st.div_busy;
			sce_pkg::ST_DYW:   cmd.store_y = !st.div_busy;
			sce_pkg::ST_CINIT: cmd.cor_init = 1'b1;
			sce_pkg::ST_CRUN:  cmd.cor_step = 1'b1;
			sce_pkg::ST_RD0,
			sce_pkg::ST_URD,
			sce_pkg::ST_ORD:   cmd.rd_p = 1'b1;
			sce_pkg::ST_DRD:   cmd.rd_pm1 = 1'b1;
			sce_pkg::ST_JMP:   cmd.jump = 1'b1;
			sce_pkg::ST_UCHK:  cmd.up_step = st.up_go;
			sce_pkg::ST_DCHK: begin
				cmd.dn_step     = st.dn_go;
				cmd.store_under = !st.dn_go;
			end
			sce_pkg::ST_OCHK:  cmd.store_over = 1'b1;
			sce_pkg::ST_MUL:   cmd.mul = 1'b1;
			sce_pkg::ST_DSET:  cmd.dset = 1'b1;
			sce_pkg::ST_FIN:   cmd.finish = 1'b1;
			sce_pkg::ST_EMIT:  cmd.emit = st.out_free;
			default: ;
		endcase
	end

endmodule

FILE: rtl/sce_dp.sv
module sce_dp #(
	parameter int TABLE_ENTRIES = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sce_pkg::cmd_t         cmd,
	output sce_pkg::st_t          st,
	input  logic                  in_op,
	input  logic [7:0]            in_index,
	input  logic [15:0]           in_value,
	input  logic signed [15:0]    in_x,
	input  logic signed [15:0]    in_y,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [15:0]           cfg_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [17:0]    out_angle,
	output logic                  out_disc
);

	localparam int TSIZE = TABLE_ENTRIES + 2;
	localparam int PW    = $clog2(TSIZE);
	localparam int TW    = PW + 22;
	localparam int NUMW  = TW + 16;
	localparam int DENW  = PW + 20;
	localparam int CW    = sce_pkg::CW;
	localparam int ZW    = sce_pkg::ZW;
	localparam int AW    = sce_pkg::AW;
	localparam int QW    = sce_pkg::QW;

	// Configuration
	logic                 enable_q;
	logic signed [15:0]   min_x_q, max_x_q, min_y_q, max_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			min_x_q  <= -16'sd1;
			max_x_q  <= -16'sd1;
			min_y_q  <= -16'sd1;
			max_y_q  <= -16'sd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sce_pkg::REG_ENABLE: enable_q <= cfg_data[0];
				sce_pkg::REG_MIN_X:  min_x_q  <= cfg_data;
				sce_pkg::REG_MAX_X:  max_x_q  <= cfg_data;
				sce_pkg::REG_MIN_Y:  min_y_q  <= cfg_data;
				sce_pkg::REG_MAX_Y:  max_y_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Hold the accepted beat
	logic                op_q;
	logic [7:0]          idx_q;
	logic [15:0]         val_q;
	logic signed [15:0]  xs_q, ys_q;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q  <= in_op;
			idx_q <= in_index;
			val_q <= in_value;
			xs_q  <= in_x;
			ys_q  <= in_y;
		end
	end

	// Correction table: inner entries in memory, mirrored ends in registers
	logic signed [AW-1:0] mem [TSIZE];
	logic signed [AW-1:0] mem_q;
	logic                 sel_lo_q, sel_hi_q;
	logic signed [AW-1:0] end_lo_q, end_hi_q;
	logic signed [AW-1:0] tv;
	logic                 idx_ok;
	logic [PW-1:0]        waddr;
	logic [PW-1:0]        raddr;
	logic [PW-1:0]        ptr_q;
	logic signed [AW-1:0] rd_val;

	assign tv     = $signed({2'b00, val_q}) - 18'sd32768;
	assign idx_ok = int'(idx_q) < TABLE_ENTRIES;
	assign waddr  = PW'(idx_q) + PW'(1);
	assign raddr  = cmd.rd_pm1 ? ptr_q - PW'(1) : ptr_q;

	always_ff @(posedge clk) begin
		if (cmd.load_we && idx_ok) begin
			mem[waddr] <= tv;
			if (int'(idx_q) == 0)
				end_lo_q <= -tv - 18'sd65536;
			if (int'(idx_q) == TABLE_ENTRIES - 1)
				end_hi_q <= 18'sd65536 - tv;
		end
		if (cmd.rd_p || cmd.rd_pm1) begin
			mem_q    <= mem[raddr];
			sel_lo_q <= raddr == '0;
			sel_hi_q <= raddr == PW'(TSIZE - 1);
		end
	end

	always_comb begin
		priority if (sel_lo_q) rd_val = end_lo_q;
		else if (sel_hi_q)     rd_val = end_hi_q;
		else                   rd_val = mem_q;
	end

	// Channel normalization setup
	logic signed [15:0]   ns, nmn, nmx;
	logic signed [18:0]   nnum;
	logic signed [16:0]   nden;
	logic [18:0]          nan;
	logic [16:0]          nad;
	logic                 nspec_q, nneg_q;
	logic [NUMW-1:0]      div_num_q;
	logic [DENW-1:0]      div_den_q;

	assign ns   = cmd.norm_x ? xs_q : ys_q;
	assign nmn  = cmd.norm_x ? min_x_q : min_y_q;
	assign nmx  = cmd.norm_x ? max_x_q : max_y_q;
	assign nnum = (19'(ns) <<< 1) - 19'(nmx) - 19'(nmn);
	assign nden = 17'(nmx) - 17'(nmn);
	assign nan  = nnum[18] ? 19'(-nnum) : 19'(nnum);
	assign nad  = nden[16] ? 17'(-nden) : 17'(nden);

	// Interpolation terms
	logic signed [PW+1:0] pm;
	logic signed [18:0]   span;
	logic signed [18:0]   span_q;
	logic signed [PW+1:0] pm_q;
	logic signed [TW-1:0] prod_q;
	logic signed [19:0]   dau_q;
	logic signed [AW-1:0] under_q, over_q;
	logic signed [TW-1:0] itot;
	logic signed [NUMW-1:0] inum, inum_p;
	logic signed [DENW-1:0] iden, iden_p;
	logic                 ineg_q;

	assign pm     = $signed({1'b0, ptr_q, 1'b0}) - $signed((PW+2)'(3));
	assign span   = 19'(over_q) - 19'(under_q);
	assign itot   = (span_q == '0) ? TW'(pm_q) : prod_q + (TW'(dau_q) <<< 1);
	assign inum   = NUMW'(itot) <<< 16;
	assign iden   = (span_q == '0) ? DENW'(2 * TABLE_ENTRIES)
	                               : DENW'(span_q) * DENW'(2 * TABLE_ENTRIES);
	assign inum_p = iden[DENW-1] ? -inum : inum;
	assign iden_p = iden[DENW-1] ? -iden : iden;

	// Divider loads
	always_ff @(posedge clk) begin
		if (cmd.norm_x || cmd.norm_y) begin
			nspec_q   <= (nden == '0) || (nan >= 19'(nad));
			nneg_q    <= (nden == '0) ? (nnum <= 0) : (nnum[18] != nden[16]);
			div_num_q <= NUMW'({nan, 14'b0});
			div_den_q <= DENW'(nad);
		end else if (cmd.dset) begin
			ineg_q    <= inum_p[NUMW-1];
			div_num_q <= inum_p[NUMW-1] ? ~inum_p : inum_p;
			div_den_q <= iden_p;
		end
	end

	logic            div_busy;
	logic [QW-1:0]   div_quo;
	logic            div_ovf;

	sce_div #(
		.NUMW (NUMW),
		.DENW (DENW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num_q),
		.den    (div_den_q),
		.busy   (div_busy),
		.quo    (div_quo),
		.ovf    (div_ovf)
	);

	// Normalized channels
	logic signed [15:0] q16;
	logic signed [15:0] xq_q, yq_q;

	assign q16 = nspec_q ? 16'sd16384 : $signed({2'b00, div_quo[13:0]});

	always_ff @(posedge clk) begin
		if (cmd.store_x) xq_q <= nneg_q ? -q16 : q16;
		if (cmd.store_y) yq_q <= nneg_q ? -q16 : q16;
	end

	// CORDIC vectoring, one rotation a cycle
	logic signed [CW-1:0] cx_q, cy_q, x0, y0;
	logic signed [ZW-1:0] cz_q;
	logic [3:0]           ccnt_q;
	logic signed [ZW-1:0] aunit;

	assign x0    = CW'(xq_q) <<< 8;
	assign y0    = CW'(yq_q) <<< 8;
	assign aunit = $signed({4'b0000, sce_pkg::atan_unit(ccnt_q)});

	always_ff @(posedge clk) begin
		if (cmd.cor_init) begin
			ccnt_q <= '0;
			if (x0[CW-1]) begin
				cx_q <= -x0;
				cy_q <= -y0;
				cz_q <= y0[CW-1] ? -18'sd32768 : 18'sd32768;
			end else begin
				cx_q <= x0;
				cy_q <= y0;
				cz_q <= '0;
			end
		end else if (cmd.cor_step) begin
			ccnt_q <= ccnt_q + 4'd1;
			if (cy_q != '0) begin
				if (!cy_q[CW-1]) begin
					cx_q <= cx_q + (cy_q >>> ccnt_q);
					cy_q <= cy_q - (cx_q >>> ccnt_q);
					cz_q <= cz_q + aunit;
				end else begin
					cx_q <= cx_q - (cy_q >>> ccnt_q);
					cy_q <= cy_q + (cx_q >>> ccnt_q);
					cz_q <= cz_q - aunit;
				end
			end
		end
	end

	// Table pointer walk
	logic signed [18:0] jdiff;
	assign jdiff = 19'(cz_q) - 19'(rd_val);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= PW'(1);
		end else if (cmd.jump) begin
			if (jdiff > 19'sd32768)
				ptr_q <= PW'(TSIZE - 1);
			else if (jdiff < -19'sd32768)
				ptr_q <= PW'(1);
		end else if (cmd.up_step) begin
			ptr_q <= ptr_q + PW'(1);
		end else if (cmd.dn_step) begin
			ptr_q <= ptr_q - PW'(1);
		end
	end

	// Neighbor entries and products
	always_ff @(posedge clk) begin
		if (cmd.store_under) under_q <= rd_val;
		if (cmd.store_over)  over_q  <= rd_val;
		if (cmd.mul) begin
			span_q <= span;
			pm_q   <= pm;
			prod_q <= TW'(pm) * TW'(span);
			dau_q  <= 20'(cz_q) - 20'(under_q);
		end
	end

	// Final rounding and clamp
	logic signed [19:0] qs, rfin;
	logic signed [AW-1:0] rsat;

	assign qs   = $signed({2'b00, div_quo});
	assign rfin = ineg_q ? -qs - 20'sd1 : qs;

	always_comb begin
		priority if (div_ovf)
			rsat = ineg_q ? AW'(sce_pkg::ANGLE_MIN) : AW'(sce_pkg::ANGLE_MAX);
		else if (rfin < 20'(sce_pkg::ANGLE_MIN))
			rsat = AW'(sce_pkg::ANGLE_MIN);
		else if (rfin > 20'(sce_pkg::ANGLE_MAX))
			rsat = AW'(sce_pkg::ANGLE_MAX);
		else
			rsat = AW'(rfin);
	end

	logic signed [AW-1:0] last_q;
	logic signed [AW-1:0] res_angle_q;
	logic                 res_disc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			last_q <= '0;
		else if (cmd.finish)
			last_q <= rsat;
	end

	always_ff @(posedge clk) begin
		priority if (cmd.res_zero) begin
			res_angle_q <= '0;
			res_disc_q  <= 1'b0;
		end else if (cmd.res_last) begin
			res_angle_q <= last_q;
			res_disc_q  <= 1'b1;
		end else if (cmd.finish) begin
			res_angle_q <= rsat;
			res_disc_q  <= 1'b0;
		end
	end

	// Output register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_angle <= res_angle_q;
			out_disc  <= res_disc_q;
		end
	end

	assign out_valid = out_valid_q;

	// Status
	assign st.op_load  = (op_q == sce_pkg::OP_LOAD);
	assign st.enabled  = enable_q;
	assign st.disc     = ((xs_q == 16'sd0) && (ys_q == 16'sd0)) ||
	                     ((xs_q == -16'sd1) && (ys_q == -16'sd1));
	assign st.div_busy = div_busy;
	assign st.cor_last = ccnt_q == 4'(sce_pkg::CORDIC_STEPS - 1);
	assign st.up_go    = (ptr_q != PW'(TSIZE - 1)) && (cz_q > rd_val);
	assign st.dn_go    = (ptr_q != PW'(1)) && (cz_q < rd_val);
	assign st.out_free = !out_valid_q || out_ready;

endmodule

FILE: rtl/sincos_encoder_angle_corrector.sv
// Sine/cosine encoder angle corrector.
// Input stream: tuser is the opcode (load table entry or process sample),
// tdata carries table_index, table_value, x_sample, y_sample.
// A load beat writes one correction table entry and yields no result beat.
// A sample beat yields one result beat: tdata holds the 18-bit angle in turns
// times 65536, tuser flags a disconnected sensor.
// Configuration writes (enable, channel min/max) go through the cfg channel,
// which is always ready; write only while no item is in flight.
// One item is processed at a time. A disabled or disconnected sample goes
// straight to its result beat. A normal sample takes longer the more table
// entries the tracking pointer moves; it runs two divider passes for the
// channels, 15 CORDIC rotations, the table walk over the single memory read
// port and one division for the interpolation.
// A finished result waits in the output register; the next item is taken
// meanwhile and stalls only when its own result is ready.
// Reset sets enable low, channel min/max to -1, the tracking pointer to 1
// and the last angle to zero; table contents are undefined until loaded.
module sincos_encoder_angle_corrector #(
	parameter int TABLE_ENTRIES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,   // table_index, table_value, x_sample, y_sample
	input  logic        s_axis_tuser,   // opcode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // angle, zero pad
	output logic        m_axis_tuser,   // disconnected
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	sce_pkg::cmd_t     cmd;
	sce_pkg::st_t      st;
	logic signed [17:0] angle;

	assign cfg_ready = 1'b1;

	sce_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.cmd     (cmd),
		.st      (st)
	);

	sce_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_op     (s_axis_tuser),
		.in_index  (s_axis_tdata[7:0]),
		.in_value  (s_axis_tdata[23:8]),
		.in_x      (s_axis_tdata[39:24]),
		.in_y      (s_axis_tdata[55:40]),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_angle (angle),
		.out_disc  (m_axis_tuser)
	);

	assign m_axis_tdata = {6'b000000, angle};

endmodule

FILE: rtl/sce_checker.sv
module sce_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [55:0] s_axis_tdata,
	input logic        s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic        m_axis_tuser,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [2:0]  cfg_index,
	input logic [15:0] cfg_data
);

	// Stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser))
		else $error("result beat changed under stall");

	// One item at a time: an accepted beat closes the input
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while busy");

	// Result angle stays in its saturation range, pad bits zero
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[23:18] == 6'd0)
		&& ($signed(m_axis_tdata[17:0]) >= -18'sd32768)
		&& ($signed(m_axis_tdata[17:0]) <= 18'sd98304))
		else $error("angle out of range");

	// A new result only follows work on an item
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result without an item in flight");

endmodule

bind sincos_encoder_angle_corrector sce_checker u_sce_checker (.*);

FILE: tb/sv/tb.sv
module tb;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		sce_pkg::op_t      op;
		logic [7:0]        idx;
		logic [15:0]       val;
		logic signed [15:0] xs;
		logic signed [15:0] ys;
	} beat_t;

	typedef struct {
		logic [17:0] angle;
		logic        disc;
	} angle_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	sincos_encoder_angle_corrector dut (.*);

	beat_t      pending_beats[$];
	angle_res_t expected_angles[$];
	int         fail_count = 0;
	longint     cycle_count = 0;

	// predictor state
	longint mdl_en, mdl_min_x, mdl_max_x, mdl_min_y, mdl_max_y;
	longint corr_tbl[0:257];
	int     mdl_ptr;
	longint mdl_last;
	longint atan_step[15] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1};

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint floor_quot(longint n, longint d);
		if (d < 0) begin
			n = -n;
			d = -d;
		end
		if (n >= 0) return n / d;
		return -((-n + d - 1) / d);
	endfunction

	// center, scale and clamp one channel to Q2.14
	function automatic longint scale_channel(longint s, longint mn, longint mx);
		longint num, den, an, ad, q;
		num = 2 * s - mx - mn;
		den = mx - mn;
		if (den == 0) return (num > 0) ? 16384 : -16384;
		an = (num < 0) ? -num : num;
		ad = (den < 0) ? -den : den;
		q = (an >= ad) ? 16384 : (an * 16384) / ad;
		return ((num < 0) != (den < 0)) ? -q : q;
	endfunction

	function automatic longint vector_angle(longint y, longint x);
		longint vx, vy, z, dx, dy;
		vx = x * 256;
		vy = y * 256;
		z = 0;
		if (x == 0 && y == 0) return 0;
		if (vx < 0) begin
			z = (vy >= 0) ? 32768 : -32768;
			vx = -vx;
			vy = -vy;
		end
		for (int i = 0; i < 15; i++) begin
			if (vy == 0) break;
			dx = vy >>> i;
			dy = vx >>> i;
			if (vy > 0) begin
				vx += dx; vy -= dy; z += atan_step[i];
			end else begin
				vx -= dx; vy += dy; z -= atan_step[i];
			end
		end
		return z;
	endfunction

	// walk the tracking pointer and interpolate
	function automatic longint interp_position(longint a);
		int p;
		longint lo, hi, span, tot, r;
		p = mdl_ptr;
		if (p < 1 || p > 257) p = 1;
		if (a - corr_tbl[p] > 32768) p = 257;
		else if (a - corr_tbl[p] < -32768) p = 1;
		while (p < 257 && a > corr_tbl[p]) p++;
		while (p > 1 && a < corr_tbl[p - 1]) p--;
		mdl_ptr = p;
		lo = corr_tbl[p - 1];
		hi = corr_tbl[p];
		span = hi - lo;
		if (span == 0) begin
			r = floor_quot((2 * longint'(p) - 3) * 65536, 512);
		end else begin
			tot = (2 * longint'(p) - 3) * span + 2 * (a - lo);
			r = floor_quot(tot * 65536, 512 * span);
		end
		if (r < -32768) r = -32768;
		if (r > 98304) r = 98304;
		return r;
	endfunction

	function automatic void predict_angle(beat_t b);
		angle_res_t e;
		longint xs, ys;
		if (b.op == sce_pkg::OP_LOAD) begin
			corr_tbl[b.idx + 1] = longint'(b.val) - 32768;
			if (b.idx == 0) corr_tbl[0] = -corr_tbl[1] - 65536;
			if (b.idx == 255) corr_tbl[257] = -corr_tbl[256] + 65536;
			return;
		end
		e.disc = 1'b0;
		e.angle = '0;
		if (mdl_en != 0) begin
			xs = b.xs;
			ys = b.ys;
			if ((xs == 0 && ys == 0) || (xs == -1 && ys == -1)) begin
				e.disc = 1'b1;
			end else begin
				mdl_last = interp_position(vector_angle(
					scale_channel(ys, mdl_min_y, mdl_max_y),
					scale_channel(xs, mdl_min_x, mdl_max_x)));
			end
			e.angle = mdl_last[17:0];
		end
		expected_angles.push_back(e);
	endfunction

	// track config writes and accepted input beats
	always @(posedge clk) begin : accept_mon
		beat_t b;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (sce_pkg::reg_idx_t'(cfg_index))
					sce_pkg::REG_ENABLE: mdl_en = longint'(cfg_data[0]);
					sce_pkg::REG_MIN_X:  mdl_min_x = longint'($signed(cfg_data));
					sce_pkg::REG_MAX_X:  mdl_max_x = longint'($signed(cfg_data));
					sce_pkg::REG_MIN_Y:  mdl_min_y = longint'($signed(cfg_data));
					sce_pkg::REG_MAX_Y:  mdl_max_y = longint'($signed(cfg_data));
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				b.op = sce_pkg::op_t'(s_axis_tuser);
				b.idx = s_axis_tdata[7:0];
				b.val = s_axis_tdata[23:8];
				b.xs = s_axis_tdata[39:24];
				b.ys = s_axis_tdata[55:40];
				predict_angle(b);
			end
		end
	end

	// check result beats against the oldest expectation
	always @(posedge clk) begin : result_mon
		angle_res_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_angles.size() == 0) begin
				$error("unexpected result beat angle=%0d", $signed(m_axis_tdata[17:0]));
				fail_count++;
			end else begin
				e = expected_angles.pop_front();
				if (m_axis_tdata[17:0] !== e.angle) begin
					$error("angle: expected %0d actual %0d", $signed(e.angle),
						$signed(m_axis_tdata[17:0]));
					fail_count++;
				end
				if (m_axis_tuser !== e.disc) begin
					$error("disconnected: expected %0d actual %0d", e.disc, m_axis_tuser);
					fail_count++;
				end
			end
		end
	end

	// send beats in bursts with gaps
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin : beat_drv
		beat_t b;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				s_axis_tvalid <= 1'b0;
			end else if (pending_beats.size() > 0) begin
				b = pending_beats.pop_front();
				s_axis_tuser <= b.op;
				s_axis_tdata <= {b.ys, b.xs, b.val, b.idx};
				s_axis_tvalid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 20);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver stall pattern, switching between modes
	int mode_left = 0;
	int stall_mode = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				mode_left <= $urandom_range(50, 400);
				stall_mode <= $urandom_range(0, 2);
			end else begin
				mode_left <= mode_left - 1;
			end
			m_axis_tready <= (stall_mode == 0) ? 1'b1 :
				(stall_mode == 1) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 7) == 0);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 4000000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic push_load(int idx, int val);
		beat_t b;
		b.op = sce_pkg::OP_LOAD;
		b.idx = 8'(idx);
		b.val = 16'(val);
		b.xs = 16'($urandom);
		b.ys = 16'($urandom);
		pending_beats.push_back(b);
	endtask

	task automatic push_sample(int x, int y);
		beat_t b;
		b.op = sce_pkg::OP_SAMPLE;
		b.idx = 8'($urandom);
		b.val = 16'($urandom);
		b.xs = 16'(x);
		b.ys = 16'(y);
		pending_beats.push_back(b);
	endtask

	task automatic write_reg(sce_pkg::reg_idx_t r, int v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data <= 16'(v);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_cal(int en, int mnx, int mxx, int mny, int mxy);
		write_reg(sce_pkg::REG_ENABLE, en);
		write_reg(sce_pkg::REG_MIN_X, mnx);
		write_reg(sce_pkg::REG_MAX_X, mxx);
		write_reg(sce_pkg::REG_MIN_Y, mny);
		write_reg(sce_pkg::REG_MAX_Y, mxy);
	endtask

	// drain everything, then let a trailing load settle
	task automatic wait_drained();
		@(posedge clk);
		while (pending_beats.size() != 0 || s_axis_tvalid || expected_angles.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// load an increasing table, some entries exactly on a multiple of 256
	task automatic load_ramp();
		int v;
		for (int k = 0; k < 256; k++) begin
			v = k * 256 + $urandom_range(0, 255);
			if (k > 0 && $urandom_range(0, 15) == 0) v = k * 256;
			push_load(k, v);
		end
	endtask

	task automatic random_phase(int n);
		int lox, hix, loy, hiy;
		lox = int'((mdl_min_x < mdl_max_x) ? mdl_min_x : mdl_max_x);
		hix = int'((mdl_min_x < mdl_max_x) ? mdl_max_x : mdl_min_x);
		loy = int'((mdl_min_y < mdl_max_y) ? mdl_min_y : mdl_max_y);
		hiy = int'((mdl_min_y < mdl_max_y) ? mdl_max_y : mdl_min_y);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 19))
				0, 1: push_load($urandom_range(0, 255), $urandom);
				2: push_sample(0, 0);
				3: push_sample(-1, -1);
				4, 5, 6, 7: push_sample($urandom, $urandom);
				default: push_sample(int'($urandom_range(lox + 32768, hix + 32768)) - 32768,
					int'($urandom_range(loy + 32768, hiy + 32768)) - 32768);
			endcase
		end
	endtask

	initial begin
		mdl_en = 0;
		mdl_min_x = -1; mdl_max_x = -1; mdl_min_y = -1; mdl_max_y = -1;
		mdl_ptr = 1;
		mdl_last = 0;
		foreach (corr_tbl[k]) corr_tbl[k] = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// disabled after reset: angle zero regardless of channels
		push_sample(1000, -1000);
		push_sample(0, 0);
		load_ramp();
		wait_drained();

		// full-scale calibration: channel extremes and disconnect cases
		write_cal(1, -32768, 32767, -32768, 32767);
		push_sample(32767, 0);
		push_sample(-32768, 0);
		push_sample(0, 32767);
		push_sample(0, -32768);
		push_sample(-32768, -32768);
		push_sample(32767, 32767);
		push_sample(-32768, 32767);
		push_sample(0, 0);
		push_sample(-1, -1);
		push_sample(-1, 0);
		wait_drained();

		// offset ranges: zero vector, then zero range on both channels
		write_cal(1, -100, 100, -50, 150);
		push_sample(0, 50);
		push_sample(100, 50);
		push_sample(-100, 150);
		wait_drained();
		write_cal(1, 7, 7, -20, -20);
		push_sample(8, -21);
		push_sample(7, -20);
		push_sample(-32768, 32767);
		wait_drained();

		// random phases across several calibrations
		write_cal(1, -20000, 20000, -18000, 21000);
		random_phase(40);
		wait_drained();
		write_cal(1, 32767, -32768, -32768, 32767);
		random_phase(30);
		wait_drained();
		write_cal(1, $urandom, $urandom, $urandom, $urandom);
		random_phase(30);
		wait_drained();
		write_cal(0, -1000, 1000, -1000, 1000);
		random_phase(15);
		wait_drained();
		load_ramp();
		wait_drained();
		write_cal(1, -1000, 1000, -900, 1100);
		random_phase(40);
		wait_drained();
		write_cal(1, 500, 500, -32768, 32767);
		random_phase(25);
		wait_drained();
		write_cal(1, -30000, 30000, -30000, 30000);
		random_phase(40);
		wait_drained();
		repeat (200) @(posedge clk);

		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
